// ----- sv/lsr_pkg.sv -----
package lsr_pkg;

    // storage geometry
    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 32;
    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS  = ADDR_BITS + 1;

    localparam logic [CNT_BITS-1:0] CNT_ONE  = CNT_BITS'(1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

    // field widths of the item ports
    localparam int MODE_BITS   = 3;
    localparam int STATUS_BITS = 3;

    // configuration port
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = 1;
    localparam logic [REG_IDX_BITS-1:0] REG_UNIQUE_ONLY = 1'b0;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_PUSH   = 3'd0,
        MODE_POP    = 3'd1,
        MODE_FIND   = 3'd2,
        MODE_REMOVE = 3'd3,
        MODE_CLEAR  = 3'd4
    } mode_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK         = 3'd0,
        ST_NOT_UNIQUE = 3'd1,
        ST_RANGE      = 3'd2,
        ST_EMPTY      = 3'd3,
        ST_FULL       = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_MOVE,
        S_POPRD,
        S_DONE
    } state_t;

    // one result item
    typedef struct packed {
        logic [WORD_BITS-1:0] word_out;
        logic                 found;
        logic [ADDR_BITS-1:0] found_position;
        status_t              status;
        logic [CNT_BITS-1:0]  occupancy;
    } res_t;

endpackage

// ----- sv/lsr_ram.sv -----
module lsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/lsr_seq.sv -----
module lsr_seq (
    input  logic                              aclk,
    input  logic                              aresetn,
    // item in
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [lsr_pkg::MODE_BITS-1:0]     s_mode,
    input  logic [lsr_pkg::WORD_BITS-1:0]     s_word_in,
    input  logic [lsr_pkg::ADDR_BITS-1:0]     s_position,
    // configuration
    input  logic                              unique_only,
    // result hand-off
    output logic                              res_valid,
    input  logic                              res_take,
    output lsr_pkg::res_t                     res,
    // entry memory
    output logic                              mem_we,
    output logic [lsr_pkg::ADDR_BITS-1:0]     mem_waddr,
    output logic [lsr_pkg::WORD_BITS-1:0]     mem_wdata,
    output logic [lsr_pkg::ADDR_BITS-1:0]     mem_raddr,
    input  logic [lsr_pkg::WORD_BITS-1:0]     mem_rdata
);

    lsr_pkg::state_t                  state_reg, state_next;
    lsr_pkg::mode_t                   mode_reg;
    logic [lsr_pkg::WORD_BITS-1:0]    word_reg;
    logic [lsr_pkg::ADDR_BITS-1:0]    pos_reg;
    logic [lsr_pkg::CNT_BITS-1:0]     count_reg, count_next;
    logic [lsr_pkg::CNT_BITS-1:0]     idx_reg, idx_next;
    logic                             pend_valid_reg, pend_valid_next;
    logic [lsr_pkg::ADDR_BITS-1:0]    pend_pos_reg, pend_pos_next;
    lsr_pkg::res_t                    res_reg, res_next;

    logic                             accept;
    logic                             hit;
    logic                             more;
    logic                             drained;
    logic                             is_empty;
    logic                             is_full;
    logic                             pos_bad;
    logic [lsr_pkg::CNT_BITS-1:0]     scan_addr;
    logic [lsr_pkg::CNT_BITS-1:0]     dst_addr;
    logic [lsr_pkg::CNT_BITS-1:0]     top_addr;

    assign s_ready   = (state_reg == lsr_pkg::S_IDLE);
    assign accept    = s_valid && s_ready;
    assign res_valid = (state_reg == lsr_pkg::S_DONE);
    assign res       = res_reg;

    // walk status
    assign hit       = pend_valid_reg && (mem_rdata == word_reg);
    assign more      = idx_reg < count_reg;
    assign drained   = !more && !pend_valid_reg;
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == lsr_pkg::CNT_FULL);
    assign pos_bad   = {1'b0, pos_reg} >= count_reg;
    assign scan_addr = count_reg - idx_reg - lsr_pkg::CNT_ONE;
    assign dst_addr  = idx_reg - lsr_pkg::CNT_ONE;
    assign top_addr  = count_reg - lsr_pkg::CNT_ONE;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lsr_pkg::S_IDLE: begin
                if (accept) begin
                    state_next = lsr_pkg::S_EXEC;
                end
            end
            lsr_pkg::S_EXEC: begin
                case (mode_reg)
                    lsr_pkg::MODE_PUSH:
                        state_next = (unique_only && !is_empty) ? lsr_pkg::S_SCAN
                                                                : lsr_pkg::S_DONE;
                    lsr_pkg::MODE_POP:
                        state_next = is_empty ? lsr_pkg::S_DONE : lsr_pkg::S_POPRD;
                    lsr_pkg::MODE_FIND:
                        state_next = is_empty ? lsr_pkg::S_DONE : lsr_pkg::S_SCAN;
                    lsr_pkg::MODE_REMOVE:
                        state_next = pos_bad ? lsr_pkg::S_DONE : lsr_pkg::S_MOVE;
                    default:
                        state_next = lsr_pkg::S_DONE;
                endcase
            end
            lsr_pkg::S_SCAN: begin
                if (hit || drained) begin
                    state_next = lsr_pkg::S_DONE;
                end
            end
            lsr_pkg::S_MOVE: begin
                if (drained) begin
                    state_next = lsr_pkg::S_DONE;
                end
            end
            lsr_pkg::S_POPRD: begin
                state_next = lsr_pkg::S_DONE;
            end
            lsr_pkg::S_DONE: begin
                if (res_take) begin
                    state_next = lsr_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = lsr_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb begin
        count_next      = count_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_pos_next   = pend_pos_reg;
        res_next        = res_reg;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[lsr_pkg::ADDR_BITS-1:0];
        mem_wdata       = word_reg;
        mem_raddr       = scan_addr[lsr_pkg::ADDR_BITS-1:0];

        case (state_reg)
            lsr_pkg::S_EXEC: begin
                res_next        = '0;
                res_next.status = lsr_pkg::ST_OK;
                idx_next        = '0;
                pend_valid_next = 1'b0;
                case (mode_reg)
                    lsr_pkg::MODE_PUSH: begin
                        if (!(unique_only && !is_empty)) begin
                            if (is_full) begin
                                res_next.status = lsr_pkg::ST_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                count_next = count_reg + lsr_pkg::CNT_ONE;
                            end
                        end
                    end
                    lsr_pkg::MODE_POP: begin
                        // read the top entry; scan_addr is the top with idx at zero
                        mem_raddr = top_addr[lsr_pkg::ADDR_BITS-1:0];
                        if (is_empty) begin
                            res_next.status = lsr_pkg::ST_EMPTY;
                        end
                    end
                    lsr_pkg::MODE_REMOVE: begin
                        if (pos_bad) begin
                            res_next.status = lsr_pkg::ST_RANGE;
                        end else begin
                            // first source is one above the removed entry
                            idx_next = count_reg - {1'b0, pos_reg};
                        end
                    end
                    lsr_pkg::MODE_CLEAR: begin
                        count_next = '0;
                    end
                    default: begin
                    end
                endcase
            end

            // search from the top, one entry per cycle, compare in the following cycle
            lsr_pkg::S_SCAN: begin
                if (hit) begin
                    pend_valid_next = 1'b0;
                    if (mode_reg == lsr_pkg::MODE_FIND) begin
                        res_next.found          = 1'b1;
                        res_next.found_position = pend_pos_reg;
                    end else begin
                        res_next.status = lsr_pkg::ST_NOT_UNIQUE;
                    end
                end else if (more) begin
                    pend_valid_next = 1'b1;
                    pend_pos_next   = idx_reg[lsr_pkg::ADDR_BITS-1:0];
                    idx_next        = idx_reg + lsr_pkg::CNT_ONE;
                end else if (pend_valid_reg) begin
                    pend_valid_next = 1'b0;
                end else if (mode_reg == lsr_pkg::MODE_PUSH) begin
                    // no duplicate held: push if there is room
                    if (is_full) begin
                        res_next.status = lsr_pkg::ST_FULL;
                    end else begin
                        mem_we     = 1'b1;
                        count_next = count_reg + lsr_pkg::CNT_ONE;
                    end
                end
            end

            // shift entries above the removed one down by one
            lsr_pkg::S_MOVE: begin
                mem_raddr = idx_reg[lsr_pkg::ADDR_BITS-1:0];
                mem_waddr = pend_pos_reg;
                mem_wdata = mem_rdata;
                mem_we    = pend_valid_reg;
                if (more) begin
                    pend_valid_next = 1'b1;
                    pend_pos_next   = dst_addr[lsr_pkg::ADDR_BITS-1:0];
                    idx_next        = idx_reg + lsr_pkg::CNT_ONE;
                end else begin
                    pend_valid_next = 1'b0;
                    if (!pend_valid_reg) begin
                        count_next = count_reg - lsr_pkg::CNT_ONE;
                    end
                end
            end

            lsr_pkg::S_POPRD: begin
                res_next.word_out = mem_rdata;
                count_next        = count_reg - lsr_pkg::CNT_ONE;
            end

            default: begin
            end
        endcase

        res_next.occupancy = count_next;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= lsr_pkg::S_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // item and walk registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg <= lsr_pkg::mode_t'(s_mode);
            word_reg <= s_word_in;
            pos_reg  <= s_position;
        end
        idx_reg      <= idx_next;
        pend_pos_reg <= pend_pos_next;
        res_reg      <= res_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= lsr_pkg::CNT_FULL)
        else $error("entry count above depth");

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> ({1'b0, mem_waddr} <= count_reg))
        else $error("entry write above the top");

    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == lsr_pkg::S_EXEC || state_reg == lsr_pkg::S_SCAN ||
                    state_reg == lsr_pkg::S_MOVE))
        else $error("entry write outside an operation");

    a_idle_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lsr_pkg::S_IDLE) |=> (count_reg == $past(count_reg)))
        else $error("count changed while idle");

    a_done_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lsr_pkg::S_DONE) |-> (res_reg.occupancy == count_reg))
        else $error("reported occupancy differs from count");
`endif

endmodule

// ----- sv/lifo_stack_with_search_and_remove.sv -----
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_mode, s_word_in, s_position
// m_        out        m_valid / m_ready  m_word_out, m_found, m_found_position,
//                                         m_status, m_occupancy
// apb       in         psel/penable/pready paddr, pwdata, prdata (unique_only at 0x0)
//
// Push without check, clear and idle codes go from EXEC to DONE; a non-empty pop
// reads the top entry in POPRD first. Find, checked push and remove walk the entry
// memory one entry per cycle through its single read port.
// Reset (aresetn low, synchronous) empties the stack; memory contents are not cleared.
// One result is held in the output register, so a new item is taken while it waits.
module lifo_stack_with_search_and_remove (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [lsr_pkg::MODE_BITS-1:0]       s_mode,
    input  logic [lsr_pkg::WORD_BITS-1:0]       s_word_in,
    input  logic [lsr_pkg::ADDR_BITS-1:0]       s_position,
    // result items
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [lsr_pkg::WORD_BITS-1:0]       m_word_out,
    output logic                                m_found,
    output logic [lsr_pkg::ADDR_BITS-1:0]       m_found_position,
    output logic [lsr_pkg::STATUS_BITS-1:0]     m_status,
    output logic [lsr_pkg::CNT_BITS-1:0]        m_occupancy,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lsr_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [lsr_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [lsr_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready
);

    logic                               unique_reg;
    logic [lsr_pkg::REG_IDX_BITS-1:0]   reg_idx;
    logic                               cfg_write;

    logic                               res_valid;
    logic                               res_take;
    lsr_pkg::res_t                      res;
    lsr_pkg::res_t                      m_res_reg;
    logic                               m_valid_reg;

    logic                               mem_we;
    logic [lsr_pkg::ADDR_BITS-1:0]      mem_waddr;
    logic [lsr_pkg::WORD_BITS-1:0]      mem_wdata;
    logic [lsr_pkg::ADDR_BITS-1:0]      mem_raddr;
    logic [lsr_pkg::WORD_BITS-1:0]      mem_rdata;

    // configuration register
    assign pready    = 1'b1;
    assign reg_idx   = paddr[lsr_pkg::APB_ADDR_BITS-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unique_reg <= 1'b0;
        end else if (cfg_write && reg_idx == lsr_pkg::REG_UNIQUE_ONLY) begin
            unique_reg <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == lsr_pkg::REG_UNIQUE_ONLY) begin
            prdata[0] = unique_reg;
        end
    end

    // sequencer
    lsr_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_word_in   (s_word_in),
        .s_position  (s_position),
        .unique_only (unique_reg),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res         (res),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    // entry memory
    lsr_ram #(
        .WIDTH (lsr_pkg::WORD_BITS),
        .DEPTH (lsr_pkg::DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register
    assign res_take = res_valid && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take) begin
            m_res_reg <= res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_word_out       = m_res_reg.word_out;
    assign m_found          = m_res_reg.found;
    assign m_found_position = m_res_reg.found_position;
    assign m_status         = m_res_reg.status;
    assign m_occupancy      = m_res_reg.occupancy;

endmodule

// ----- sim/lifo_stack_with_search_and_remove_tb.sv -----
module lifo_stack_with_search_and_remove_tb;

    localparam int DEPTH         = lsr_pkg::DEPTH;
    localparam int WORD_BITS     = lsr_pkg::WORD_BITS;
    localparam int ADDR_BITS     = lsr_pkg::ADDR_BITS;
    localparam int CNT_BITS      = lsr_pkg::CNT_BITS;
    localparam int MODE_BITS     = lsr_pkg::MODE_BITS;
    localparam int STATUS_BITS   = lsr_pkg::STATUS_BITS;
    localparam int APB_ADDR_BITS = lsr_pkg::APB_ADDR_BITS;
    localparam int APB_DATA_BITS = lsr_pkg::APB_DATA_BITS;

    // mode codes that the block treats as no operation
    localparam logic [MODE_BITS-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_BITS-1:0] MODE_SPARE_HI = 3'd7;
    localparam logic [WORD_BITS-1:0] WORD_ONES     = '1;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = DEPTH + 16;

    typedef enum int {RX_ALWAYS, RX_HALF, RX_MOSTLY, RX_TOGGLE} rx_style_t;

    // stack predictor and queue of expected result items
    class stack_scoreboard;
        logic [WORD_BITS-1:0] held_words[$];   // index 0 is the bottom
        lsr_pkg::res_t        expected_results[$];
        bit                   unique_only;
        int                   errors;

        // position from the top of the nearest copy of word, -1 if none
        function int nearest_match(logic [WORD_BITS-1:0] word);
            for (int p = 0; p < held_words.size(); p++) begin
                if (held_words[held_words.size() - 1 - p] == word) return p;
            end
            return -1;
        endfunction

        function void note_input(logic [MODE_BITS-1:0] mode, logic [WORD_BITS-1:0] word,
                                 logic [ADDR_BITS-1:0] pos);
            lsr_pkg::res_t outcome;
            int            hit;
            outcome        = '0;
            outcome.status = lsr_pkg::ST_OK;
            hit            = nearest_match(word);
            case (mode)
                lsr_pkg::MODE_PUSH: begin
                    // duplicate check takes priority over the full check
                    if (unique_only && hit >= 0) outcome.status = lsr_pkg::ST_NOT_UNIQUE;
                    else if (held_words.size() >= DEPTH) outcome.status = lsr_pkg::ST_FULL;
                    else held_words.push_back(word);
                end
                lsr_pkg::MODE_POP: begin
                    if (held_words.size() == 0) outcome.status = lsr_pkg::ST_EMPTY;
                    else outcome.word_out = held_words.pop_back();
                end
                lsr_pkg::MODE_FIND: begin
                    if (hit >= 0) begin
                        outcome.found          = 1'b1;
                        outcome.found_position = ADDR_BITS'(hit);
                    end
                end
                lsr_pkg::MODE_REMOVE: begin
                    if (int'(pos) >= held_words.size()) outcome.status = lsr_pkg::ST_RANGE;
                    else held_words.delete(held_words.size() - 1 - int'(pos));
                end
                lsr_pkg::MODE_CLEAR: held_words.delete();
                default: ;
            endcase
            outcome.occupancy = CNT_BITS'(held_words.size());
            expected_results.push_back(outcome);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [WORD_BITS-1:0] word, logic found,
                                   logic [ADDR_BITS-1:0] fpos, logic [STATUS_BITS-1:0] status,
                                   logic [CNT_BITS-1:0] occupancy);
            lsr_pkg::res_t want;
            if (expected_results.size() == 0) begin
                $display("%0t: result item with none expected, expected nothing, got word %0h",
                         $time, word);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("word_out", want.word_out, word);
            compare_field("found", want.found, found);
            compare_field("found_position", want.found_position, fpos);
            compare_field("status", want.status, status);
            compare_field("occupancy", want.occupancy, occupancy);
        endfunction
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [MODE_BITS-1:0]     s_mode;
    logic [WORD_BITS-1:0]     s_word_in;
    logic [ADDR_BITS-1:0]     s_position;
    logic                     m_valid;
    logic                     m_ready;
    logic [WORD_BITS-1:0]     m_word_out;
    logic                     m_found;
    logic [ADDR_BITS-1:0]     m_found_position;
    logic [STATUS_BITS-1:0]   m_status;
    logic [CNT_BITS-1:0]      m_occupancy;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    stack_scoreboard sb = new();
    int              burst_left;
    int              hold_req;

    lifo_stack_with_search_and_remove uut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // limit on the whole run
    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    // both handshakes are observed at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result(m_word_out, m_found, m_found_position, m_status, m_occupancy);
            if (s_valid && s_ready)
                sb.note_input(s_mode, s_word_in, s_position);
        end
    end

    // result side: changing stall styles, plus one long hold-off on request
    initial begin
        rx_style_t style;
        int        tick;
        m_ready = 1'b0;
        style   = RX_ALWAYS;
        tick    = 0;
        forever begin
            @(negedge aclk);
            if (hold_req != 0) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_req = 0;
            end else begin
                if (tick % 64 == 0) style = rx_style_t'($urandom_range(0, 3));
                tick++;
                case (style)
                    RX_ALWAYS: m_ready <= 1'b1;
                    RX_HALF:   m_ready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY: m_ready <= ($urandom_range(0, 9) != 0);
                    default:   m_ready <= ~m_ready;
                endcase
            end
        end
    end

    // offer one item and hold it until taken; most bursts end in a random gap
    task automatic send_item(input logic [MODE_BITS-1:0] mode, input logic [WORD_BITS-1:0] word,
                             input logic [ADDR_BITS-1:0] pos);
        int gap;
        @(negedge aclk);
        s_valid    <= 1'b1;
        s_mode     <= mode;
        s_word_in  <= word;
        s_position <= pos;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 10);
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    // stop offering and wait for every outstanding result item
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_unique(input bit value);
        wait_drained();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_BITS'(4 * lsr_pkg::REG_UNIQUE_ONLY);
        pwdata  <= APB_DATA_BITS'(value);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.unique_only = value;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // small values and extremes are common so that matches happen
    function automatic logic [WORD_BITS-1:0] random_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return WORD_ONES;
            2, 3, 4: return WORD_BITS'($urandom_range(0, 15));
            default: return $urandom();
        endcase
    endfunction

    task automatic send_random(input int push_w, input int clear_w);
        logic [MODE_BITS-1:0] mode;
        logic [WORD_BITS-1:0] word;
        logic [ADDR_BITS-1:0] pos;
        int                   pick;
        int                   held;
        held = sb.held_words.size();
        word = random_word();
        pos  = ADDR_BITS'($urandom_range(0, DEPTH - 1));
        pick = $urandom_range(0, push_w + clear_w + 48);
        if (pick < push_w) begin
            mode = lsr_pkg::MODE_PUSH;
            if (held > 0 && $urandom_range(0, 4) == 0)
                word = sb.held_words[$urandom_range(0, held - 1)];
        end else if (pick < push_w + 18) begin
            mode = lsr_pkg::MODE_POP;
        end else if (pick < push_w + 32) begin
            mode = lsr_pkg::MODE_FIND;
            if (held > 0 && $urandom_range(0, 4) < 3)
                word = sb.held_words[$urandom_range(0, held - 1)];
        end else if (pick < push_w + 46) begin
            mode = lsr_pkg::MODE_REMOVE;
            if (held > 0 && $urandom_range(0, 9) < 7)
                pos = ADDR_BITS'($urandom_range(0, held - 1));
        end else if (pick < push_w + 46 + clear_w) begin
            mode = lsr_pkg::MODE_CLEAR;
        end else begin
            mode = MODE_BITS'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        end
        send_item(mode, word, pos);
    endtask

    task automatic run_phase(input int count, input int push_w, input int clear_w,
                             input int hold_at);
        for (int i = 0; i < count; i++) begin
            if (i == hold_at) hold_req = 1;
            send_random(push_w, clear_w);
        end
    endtask

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_mode     = lsr_pkg::MODE_PUSH;
        s_word_in  = '0;
        s_position = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        burst_left = 1;
        hold_req   = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty store, spare modes, extremes, middle removal, duplicate check
        write_unique(1'b0);
        send_item(lsr_pkg::MODE_POP, '0, '0);
        send_item(lsr_pkg::MODE_REMOVE, '0, '0);
        send_item(lsr_pkg::MODE_FIND, '0, '0);
        send_item(lsr_pkg::MODE_CLEAR, '0, '0);
        for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++)
            send_item(MODE_BITS'(m), WORD_ONES, '1);
        send_item(lsr_pkg::MODE_PUSH, '0, '0);
        send_item(lsr_pkg::MODE_PUSH, WORD_ONES, '0);
        send_item(lsr_pkg::MODE_PUSH, '0, '0);
        send_item(lsr_pkg::MODE_PUSH, 32'hA5A5_A5A5, '0);
        send_item(lsr_pkg::MODE_FIND, '0, '0);
        send_item(lsr_pkg::MODE_FIND, WORD_ONES, '0);
        send_item(lsr_pkg::MODE_FIND, 32'h1234_5678, '0);
        send_item(lsr_pkg::MODE_REMOVE, '0, '1);
        send_item(lsr_pkg::MODE_REMOVE, '0, 6'd4);
        send_item(lsr_pkg::MODE_REMOVE, '0, 6'd1);
        send_item(lsr_pkg::MODE_FIND, '0, '0);
        send_item(lsr_pkg::MODE_REMOVE, '0, 6'd2);
        send_item(lsr_pkg::MODE_POP, '0, '0);
        send_item(lsr_pkg::MODE_POP, '0, '0);
        send_item(lsr_pkg::MODE_POP, '0, '0);
        send_item(lsr_pkg::MODE_PUSH, 32'h5A5A_5A5A, '0);
        send_item(lsr_pkg::MODE_CLEAR, '0, '0);
        write_unique(1'b1);
        send_item(lsr_pkg::MODE_PUSH, 32'h7, '0);
        send_item(lsr_pkg::MODE_PUSH, 32'h7, '0);
        send_item(lsr_pkg::MODE_FIND, 32'h7, '0);

        // random phases: mixed, filling with and without the duplicate check
        write_unique(1'b0);
        run_phase(250, 40, 2, 100);
        write_unique(1'b1);
        run_phase(260, 75, 0, -1);
        write_unique(1'b0);
        run_phase(200, 75, 0, -1);
        write_unique(1'b1);
        run_phase(120, 30, 3, -1);
        wait_drained();
        run_phase(120, 30, 3, -1);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/lsr_pkg.sv
sv/lsr_ram.sv
sv/lsr_seq.sv
sv/lifo_stack_with_search_and_remove.sv
sim/lifo_stack_with_search_and_remove_tb.sv
